FILE: src/sha1h_pkg.sv
// sha1h_pkg: shared types, constants and key states for the sha1 hmac block
// no dependencies
`timescale 1ns / 1ps
package sha1h_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [63:0] HMAC_START_BITS = 64'd512;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [4:0]  INNER_BYTES = 5'h14;

    localparam logic [1:0] REG_HASH_MODE   = 2'd0;
    localparam logic [1:0] REG_KEY_VERSION = 2'd1;

    typedef logic [4:0][31:0] chain_t;

    localparam chain_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    localparam chain_t INNER_STATE [4] = '{
        {32'h4BD717A4, 32'h77C32E3C, 32'h6D86A50C, 32'hE04613D2, 32'h85F9E51A},
        {32'h99958DAC, 32'hF55E226B, 32'hBE609BEA, 32'h336472B9, 32'h72127625},
        {32'h86BBD7ED, 32'h40B4389D, 32'hDBC6B498, 32'hC9BD25E8, 32'h39B06E79},
        {32'h08995B2C, 32'h8A3D920D, 32'h865A9762, 32'hF97D4E0E, 32'h8058763A}
    };

    localparam chain_t OUTER_STATE [4] = '{
        {32'h486B52B3, 32'h3137AB34, 32'hB82CCDBC, 32'hE1922BEB, 32'h5D7A9C6B},
        {32'hC4FE2DE8, 32'hB256FACA, 32'h2E8EF85E, 32'h4DE82659, 32'h76441D41},
        {32'hD96E7393, 32'hEBFE5FE5, 32'h6B8749CD, 32'h84B430FC, 32'h9B49BED3},
        {32'h168A5609, 32'h88DA9992, 32'h1186EEEA, 32'hA2F1E037, 32'h01075307}
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_of_message;
    } item_t;

    typedef struct packed {
        logic  vld;
        item_t item;
    } qhead_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMP,
        ST_ADD,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_FIN,
        ST_INNER,
        ST_OUT
    } state_t;

endpackage

FILE: src/sha1h_if.sv
// sha1h_if: valid/ready channel interfaces for message beats and digest beats
// depends on nothing
`timescale 1ns / 1ps
interface sha1h_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_message;
    modport source (output valid, data_byte, byte_valid, last_of_message, input ready);
    modport sink (input valid, data_byte, byte_valid, last_of_message, output ready);
endinterface

interface sha1h_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: src/sha1h_front.sv
// sha1h_front: takes message beats, drops beats that carry nothing, queues the rest
// depends on sha1h_pkg and sha1h_if
`timescale 1ns / 1ps
module sha1h_front (
    input  logic              clk,
    input  logic              rst_n,
    sha1h_msg_if.sink         msg,
    output sha1h_pkg::qhead_t head,
    input  logic              pop
);
    localparam int PW = $clog2(sha1h_pkg::QUEUE_DEPTH);

    sha1h_pkg::item_t mem_reg [sha1h_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          push, keep, do_pop;

    assign msg.ready = (cnt_reg != (PW+1)'(sha1h_pkg::QUEUE_DEPTH));
    assign keep      = msg.byte_valid | msg.last_of_message;
    assign push      = msg.valid & msg.ready & keep;
    assign do_pop    = pop & (cnt_reg != '0);

    assign head = {(cnt_reg != '0), mem_reg[rptr_reg]};

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (PW+1)'(push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= '{msg.data_byte, msg.byte_valid, msg.last_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule

FILE: src/sha1h_back.sv
// sha1h_back: block buffer, padding sequencer, 80-round compression, hmac passes
// depends on sha1h_pkg and sha1h_if
`timescale 1ns / 1ps
module sha1h_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sha1h_pkg::qhead_t head,
    output logic              pop,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    sha1h_dig_if.source       dig
);
    sha1h_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    sha1h_pkg::chain_t chain_reg, chain_next;
    logic [511:0]  buf_reg, buf_next;
    logic [5:0]    fill_reg, fill_next;
    logic [63:0]   bits_reg, bits_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]   a_next, b_next, c_next, d_next, e_next;
    logic [159:0]  inner_reg, inner_next;
    logic          outer_reg, outer_next;
    logic          mode_reg, mode_next;
    logic [1:0]    ver_reg, ver_next;
    logic [31:0]   f, k, wnew, tmp;
    logic          ab_en;
    logic [7:0]    ab_byte;

    always_comb
    begin
        if (cnt_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1h_pkg::K0;
        end
        else if (cnt_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1h_pkg::K1;
        end
        else if (cnt_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1h_pkg::K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1h_pkg::K3;
        end
        wnew = buf_reg[95:64] ^ buf_reg[255:224] ^ buf_reg[447:416] ^ buf_reg[511:480];
        wnew = {wnew[30:0], wnew[31]};
        tmp  = {a_reg[26:0], a_reg[31:27]} + f + e_reg + buf_reg[511:480] + k;
    end

    assign dig.valid       = (state_reg == sha1h_pkg::ST_OUT);
    assign dig.digest_word = chain_reg[cnt_reg[2:0]];
    assign dig.word_index  = cnt_reg[2:0];
    assign dig.last_word   = (cnt_reg[2:0] == 3'd4);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        chain_next = chain_reg;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        cnt_next   = cnt_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg; e_next = e_reg;
        inner_next = inner_reg;
        outer_next = outer_reg;
        mode_next  = mode_reg;
        ver_next   = ver_reg;
        pop        = 1'b0;
        ab_en      = 1'b0;
        ab_byte    = 8'h00;

        case (state_reg)
            sha1h_pkg::ST_IDLE:
            begin
                if (head.vld)
                begin
                    pop = 1'b1;
                    if (head.item.byte_valid)
                    begin
                        ab_en     = 1'b1;
                        ab_byte   = head.item.data_byte;
                        bits_next = bits_reg + 64'd8;
                    end
                    ret_next = head.item.last_of_message ? sha1h_pkg::ST_PAD80
                                                         : sha1h_pkg::ST_IDLE;
                    if (!(head.item.byte_valid && fill_reg == 6'd63))
                    begin
                        state_next = ret_next;
                    end
                end
            end
            sha1h_pkg::ST_PAD80:
            begin
                ab_en      = 1'b1;
                ab_byte    = sha1h_pkg::PAD_MARK;
                ret_next   = sha1h_pkg::ST_PADZ;
                state_next = sha1h_pkg::ST_PADZ;
            end
            sha1h_pkg::ST_PADZ:
            begin
                if (fill_reg == 6'd56)
                begin
                    state_next = sha1h_pkg::ST_PADLEN;
                end
                else
                begin
                    ab_en    = 1'b1;
                    ret_next = sha1h_pkg::ST_PADZ;
                end
            end
            sha1h_pkg::ST_PADLEN:
            begin
                ab_en     = 1'b1;
                ab_byte   = bits_reg[63:56];
                bits_next = {bits_reg[55:0], 8'h00};
                ret_next  = sha1h_pkg::ST_FIN;
            end
            sha1h_pkg::ST_COMP:
            begin
                e_next   = d_reg;
                d_next   = c_reg;
                c_next   = {b_reg[1:0], b_reg[31:2]};
                b_next   = a_reg;
                a_next   = tmp;
                buf_next = {buf_reg[479:0], wnew};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd79)
                begin
                    state_next = sha1h_pkg::ST_ADD;
                end
            end
            sha1h_pkg::ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                cnt_next      = '0;
                state_next    = ret_reg;
            end
            sha1h_pkg::ST_FIN:
            begin
                cnt_next = '0;
                if (mode_reg && !outer_reg)
                begin
                    inner_next = chain_reg;
                    inner_next = {chain_reg[0], chain_reg[1], chain_reg[2],
                                  chain_reg[3], chain_reg[4]};
                    chain_next = sha1h_pkg::OUTER_STATE[ver_reg];
                    bits_next  = sha1h_pkg::HMAC_START_BITS;
                    outer_next = 1'b1;
                    state_next = sha1h_pkg::ST_INNER;
                end
                else
                begin
                    state_next = sha1h_pkg::ST_OUT;
                end
            end
            sha1h_pkg::ST_INNER:
            begin
                ab_en      = 1'b1;
                ab_byte    = inner_reg[159:152];
                inner_next = {inner_reg[151:0], 8'h00};
                bits_next  = bits_reg + 64'd8;
                cnt_next   = cnt_reg + 7'd1;
                if (cnt_reg[4:0] == sha1h_pkg::INNER_BYTES - 5'd1)
                begin
                    cnt_next   = '0;
                    state_next = sha1h_pkg::ST_PAD80;
                end
            end
            sha1h_pkg::ST_OUT:
            begin
                if (dig.ready)
                begin
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg[2:0] == 3'd4)
                    begin
                        cnt_next   = '0;
                        chain_next = mode_reg ? sha1h_pkg::INNER_STATE[ver_reg]
                                              : sha1h_pkg::SHA1_IV;
                        bits_next  = mode_reg ? sha1h_pkg::HMAC_START_BITS : '0;
                        fill_next  = '0;
                        outer_next = 1'b0;
                        state_next = sha1h_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha1h_pkg::ST_IDLE;
            end
        endcase

        // byte append, and compression start on a full block
        if (ab_en)
        begin
            buf_next  = {buf_reg[503:0], ab_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == 6'd63)
            begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                e_next     = chain_reg[4];
                cnt_next   = '0;
                state_next = sha1h_pkg::ST_COMP;
            end
            else if (state_reg == sha1h_pkg::ST_PADLEN)
            begin
                state_next = sha1h_pkg::ST_PADLEN;
            end
        end

        if (cfg_we && (cfg_index == sha1h_pkg::REG_HASH_MODE ||
                       cfg_index == sha1h_pkg::REG_KEY_VERSION))
        begin
            if (cfg_index == sha1h_pkg::REG_HASH_MODE)
            begin
                mode_next = cfg_data[0];
            end
            else
            begin
                ver_next = cfg_data;
            end
            chain_next = mode_next ? sha1h_pkg::INNER_STATE[ver_next] : sha1h_pkg::SHA1_IV;
            bits_next  = mode_next ? sha1h_pkg::HMAC_START_BITS : '0;
            fill_next  = '0;
            outer_next = 1'b0;
            cnt_next   = '0;
            state_next = sha1h_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        inner_reg <= inner_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1h_pkg::ST_IDLE;
            ret_reg   <= sha1h_pkg::ST_IDLE;
            chain_reg <= sha1h_pkg::SHA1_IV;
            fill_reg  <= '0;
            bits_reg  <= '0;
            cnt_reg   <= '0;
            outer_reg <= 1'b0;
            mode_reg  <= 1'b0;
            ver_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            chain_reg <= chain_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            cnt_reg   <= cnt_next;
            outer_reg <= outer_next;
            mode_reg  <= mode_next;
            ver_reg   <= ver_next;
        end
    end
endmodule

FILE: src/sha1_with_preset_key_hmac.sv
// sha1_with_preset_key_hmac: top level, byte-fed sha-1 with preset-key hmac
// depends on sha1h_pkg, sha1h_if, sha1h_front, sha1h_back
//
//  channel  dir  beat                                         accepted when
//  msg      in   data_byte, byte_valid, last_of_message        msg.valid & msg.ready
//  dig      out  digest_word, word_index, last_word            dig.valid & dig.ready
//  cfg      in   cfg_index, cfg_data                           cfg_we
//
// bytes are appended at one per cycle; each full 64-byte block then runs in the
// shared round unit (80 rounds and the chaining add) before more bytes are taken
// a message end adds padding at one byte per cycle, stalling for each full block,
// an hmac outer pass, then 5 digest beats; a 2-beat queue holds msg beats meanwhile
// rst_n is asynchronous, active low; the back end waits while dig is stalled
`timescale 1ns / 1ps
module sha1_with_preset_key_hmac (
    input  logic        clk,
    input  logic        rst_n,
    sha1h_msg_if.sink   msg,
    sha1h_dig_if.source dig,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);
    sha1h_pkg::qhead_t head;
    logic              pop;

    sha1h_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .head  (head),
        .pop   (pop)
    );

    sha1h_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dig       (dig)
    );
endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for sha1_with_preset_key_hmac, plain sha-1 and preset-key hmac
// depends on sha1h_pkg, sha1h_if and the block; a built-in predictor checks every digest beat
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [1:0] cfg_data;

    sha1h_msg_if msg ();
    sha1h_dig_if dig ();

    sha1_with_preset_key_hmac dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg.sink),
        .dig       (dig.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sha1h_pkg::item_t pending_bytes [$];
    digest_beat_t     digests_due [$];
    int  errors = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  took = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  hold_left = 0;

    // predictor state
    logic        mode_q;
    logic [1:0]  ver_q;
    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] nbits;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
                w[t%16] = rotl(w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16], 1);
            if (t < 20)
            begin
                f = (b & c) | (~b & d); k = sha1h_pkg::K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d; k = sha1h_pkg::K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = sha1h_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d; k = sha1h_pkg::K3;
            end
            t2 = rotl(a, 5) + f + e + w[t%16] + k;
            e = d; d = c; c = rotl(b, 30); b = a; a = t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic absorb_byte(input logic [7:0] v);
        blk[fill] = v;
        nbits += 64'd8;
        if (fill == 6'd63)
            compress_block();
        fill = fill + 6'd1;
    endtask

    task automatic pad_and_close();
        int i;
        i = int'(fill);
        blk[i] = sha1h_pkg::PAD_MARK;
        i++;
        if (i > 56)
        begin
            while (i < 64)
            begin
                blk[i] = 8'h00; i++;
            end
            compress_block();
            i = 0;
        end
        while (i < 56)
        begin
            blk[i] = 8'h00; i++;
        end
        for (int j = 0; j < 8; j++)
            blk[56+j] = nbits[63-8*j -: 8];
        compress_block();
        fill = 0;
    endtask

    task automatic load_start();
        for (int i = 0; i < 5; i++)
            chain[i] = mode_q ? sha1h_pkg::INNER_STATE[ver_q][i] : sha1h_pkg::SHA1_IV[i];
        nbits = mode_q ? sha1h_pkg::HMAC_START_BITS : 64'd0;
        fill = 0;
    endtask

    task automatic predict_digest(input sha1h_pkg::item_t it);
        logic [31:0] inner [5];
        digest_beat_t db;
        if (it.byte_valid)
            absorb_byte(it.data_byte);
        if (it.last_of_message)
        begin
            pad_and_close();
            if (mode_q)
            begin
                inner = chain;
                for (int i = 0; i < 5; i++)
                    chain[i] = sha1h_pkg::OUTER_STATE[ver_q][i];
                nbits = sha1h_pkg::HMAC_START_BITS;
                fill = 0;
                for (int i = 0; i < sha1h_pkg::INNER_BYTES; i++)
                    absorb_byte(inner[i/4][31-8*(i%4) -: 8]);
                pad_and_close();
            end
            for (int i = 0; i < 5; i++)
            begin
                db.word = chain[i];
                db.idx = i[2:0];
                db.last = (i == 4);
                digests_due.push_back(db);
            end
            load_start();
        end
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // message driver
    always @(negedge clk)
    begin
        sha1h_pkg::item_t it;
        if (!msg.valid || took)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                it = pending_bytes.pop_front();
                msg.valid <= 1'b1;
                msg.data_byte <= it.data_byte;
                msg.byte_valid <= it.byte_valid;
                msg.last_of_message <= it.last_of_message;
            end
            else
                msg.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        sha1h_pkg::item_t it;
        took = msg.valid && msg.ready;
        if (took)
        begin
            it.data_byte = msg.data_byte;
            it.byte_valid = msg.byte_valid;
            it.last_of_message = msg.last_of_message;
            predict_digest(it);
        end
    end

    // digest receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            dig.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            dig.ready <= 1'b0;
        end
        else
            dig.ready <= ($urandom_range(99) >= recv_idle);
    end

    // digest monitor
    always @(posedge clk)
    begin
        digest_beat_t db;
        if (dig.valid && dig.ready)
        begin
            if (digests_due.size() == 0)
            begin
                $display("%0t unexpected digest beat %h idx %0d", $time,
                         dig.digest_word, dig.word_index);
                errors++;
            end
            else
            begin
                db = digests_due.pop_front();
                if (dig.digest_word !== db.word || dig.word_index !== db.idx ||
                    dig.last_word !== db.last)
                begin
                    $display("%0t mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                             db.word, db.idx, db.last,
                             dig.digest_word, dig.word_index, dig.last_word);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == sha1h_pkg::REG_HASH_MODE)
        begin
            mode_q = value[0];
            load_start();
        end
        else if (index == sha1h_pkg::REG_KEY_VERSION)
        begin
            ver_q = value;
            load_start();
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] v, input logic bv, input logic lm);
        sha1h_pkg::item_t it;
        it.data_byte = v;
        it.byte_valid = bv;
        it.last_of_message = lm;
        pending_bytes.push_back(it);
    endtask

    task automatic push_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(1))
                push_byte(8'($urandom_range(255)), 1'b1, 1'b1);
            else
                push_byte(8'($urandom_range(255)), 1'b1, 1'b0);
        end
        if (len == 0 || !pending_bytes[$].last_of_message)
            push_byte(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // one optional long message (full block in the body, extra padding block),
    // then short messages
    task automatic push_messages(input int n_items, input int long_len);
        int cnt, len;
        cnt = 0;
        if (long_len > 0)
            push_message(long_len);
        while (cnt < n_items)
        begin
            len = int'($urandom_range(16));
            push_message(len);
            cnt += len + 1;
        end
    endtask

    task automatic drain_phase();
        while (pending_bytes.size() != 0 || msg.valid)
            @(posedge clk);
        while (digests_due.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    initial
    begin
        logic [1:0] modes [6] = '{2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0};
        logic [1:0] vers  [6] = '{2'd0, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        msg.valid = 1'b0;
        msg.data_byte = '0;
        msg.byte_valid = 1'b0;
        msg.last_of_message = 1'b0;
        dig.ready = 1'b0;
        mode_q = 1'b0;
        ver_q = 2'd0;
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        load_start();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 26 : (ph < 4) ? 81 : 0;
            recv_idle = (ph < 2) ? 81 : (ph < 4) ? 26 : 0;
            write_reg(sha1h_pkg::REG_HASH_MODE, modes[ph]);
            write_reg(sha1h_pkg::REG_KEY_VERSION, vers[ph]);
            if (ph == 1)
                write_reg(REG_UNUSED, 2'd1);
            if (ph == 0 || ph == 1)
            begin
                // empty message, noise, extreme bytes, one-byte message
                push_byte(8'hFF, 1'b0, 1'b1);
                push_byte(8'h00, 1'b0, 1'b0);
                push_byte(8'h00, 1'b1, 1'b0);
                push_byte(8'hFF, 1'b1, 1'b0);
                push_byte(8'hA5, 1'b1, 1'b1);
                push_byte(8'h5A, 1'b1, 1'b1);
            end
            if (ph == 2)
                hold_req = 1'b1;
            push_messages((ph == 5) ? 0 : 4, (ph == 5) ? 120 : 0);
            drain_phase();
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("status: fail");
        $finish;
    end
endmodule
